// ===== design/rja_pkg.sv =====
// Shared types, moduli and base matrices for the jump-ahead engine.
`timescale 1ns / 1ps
package rja_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [31:0] first_word_a;
        logic [31:0] first_word_b;
        logic [31:0] first_word_c;
        logic [31:0] second_word_a;
        logic [31:0] second_word_b;
        logic [31:0] second_word_c;
        logic        last_stream;
    } t_in_req;

    typedef struct packed {
        logic [31:0] new_first_a;
        logic [31:0] new_first_b;
        logic [31:0] new_first_c;
        logic [31:0] new_second_a;
        logic [31:0] new_second_b;
        logic [31:0] new_second_c;
        logic        batch_end;
    } t_out_req;

    typedef struct packed {
        logic start;
        logic sel;
    } t_mac_ctl;

    localparam t_word       MOD_ONE  = 32'd4294967087;
    localparam t_word       MOD_TWO  = 32'd4294944443;
    localparam logic [14:0] DIFF_ONE = 15'd209;
    localparam logic [14:0] DIFF_TWO = 15'd22853;

    localparam logic       REG_JUMP_LOG2  = 1'b0;
    localparam logic       REG_JUMP_COUNT = 1'b1;

    function automatic t_word base_entry(input logic comp, input logic inv,
                                         input logic [3:0] idx);
        t_word v;
        v = '0;
        unique case ({comp, inv})
            2'b00: begin
                if (idx == 4'd1 || idx == 4'd5) v = 32'd1;
                if (idx == 4'd6) v = 32'd4294156359;
                if (idx == 4'd7) v = 32'd1403580;
            end
            2'b10: begin
                if (idx == 4'd1 || idx == 4'd5) v = 32'd1;
                if (idx == 4'd6) v = 32'd4293573854;
                if (idx == 4'd8) v = 32'd527612;
            end
            2'b01: begin
                if (idx == 4'd0) v = 32'd184888585;
                if (idx == 4'd2) v = 32'd1945170933;
                if (idx == 4'd3 || idx == 4'd7) v = 32'd1;
            end
            2'b11: begin
                if (idx == 4'd1) v = 32'd360363334;
                if (idx == 4'd2) v = 32'd4225571728;
                if (idx == 4'd3 || idx == 4'd7) v = 32'd1;
            end
        endcase
        return v;
    endfunction

endpackage

// ===== design/rng_jump_ahead_engine_unit.sv =====
// Top level: jump matrix builder and state advance sequencer over one shared modular MAC.
// A request with matrices built takes 18 MACs, then the result is loaded into the output register.
// The first request after reset or any register write also builds both matrices: up to 2
// matrix products per bit of |c| plus |e|+1 products if e is nonzero, for each component.
// Throughput: one request at a time; a stalled result holds back the next result, and so the input, until it leaves.
// Reset: synchronous active low; config registers cleared to zero, matrices marked unbuilt.
`timescale 1ns / 1ps
module rng_jump_ahead_engine_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  rja_pkg::t_in_req  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rja_pkg::t_out_req o_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_CTEST  = 4'd2;
    localparam logic [3:0] S_EINIT  = 4'd3;
    localparam logic [3:0] S_ELOOP  = 4'd4;
    localparam logic [3:0] S_STORE  = 4'd5;
    localparam logic [3:0] S_MMGO   = 4'd6;
    localparam logic [3:0] S_MMWT   = 4'd7;
    localparam logic [3:0] S_MMCP   = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    localparam logic [1:0] OP_OB = 2'd0;
    localparam logic [1:0] OP_BB = 2'd1;
    localparam logic [1:0] OP_BO = 2'd2;
    localparam logic [1:0] OP_AP = 2'd3;

    logic [3:0]  r_state, r_ret;
    logic [1:0]  r_op;
    logic [1:0]  r_i, r_j, r_k;
    logic        r_comp;
    logic        r_ready;
    logic [8:0]  r_log2;
    logic [31:0] r_count;
    logic [31:0] r_n;
    logic [8:0]  r_cnt;
    logic        r_last;
    logic        r_out_valid;
    rja_pkg::t_out_req r_out;
    rja_pkg::t_word r_acc;

    rja_pkg::t_word r_o [9];
    rja_pkg::t_word r_b [9];
    rja_pkg::t_word r_b2[9];
    rja_pkg::t_word r_r [9];
    rja_pkg::t_word r_j1[9];
    rja_pkg::t_word r_j2[9];
    rja_pkg::t_word r_x [6];
    rja_pkg::t_word r_y [6];

    logic [3:0]  w_xa, w_ya, w_oa;
    logic [2:0]  w_vi, w_yi;
    rja_pkg::t_word w_ord, w_a, w_b, w_res;
    logic        w_done;
    logic        w_e_neg, w_c_neg;
    logic [8:0]  w_e_mag;
    logic [31:0] w_c_mag;
    rja_pkg::t_mac_ctl w_ctl;
    logic        w_in_acc, w_out_acc;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign w_xa = 4'(r_i) * 4'd3 + 4'(r_k);
    assign w_ya = 4'(r_k) * 4'd3 + 4'(r_j);
    assign w_oa = (r_op == OP_BO) ? w_ya : w_xa;
    assign w_vi = (r_comp ? 3'd3 : 3'd0) + 3'(r_k);
    assign w_yi = (r_comp ? 3'd3 : 3'd0) + 3'(r_i);
    assign w_ord = r_o[w_oa];

    always_comb begin
        unique case (r_op)
            OP_OB:   begin w_a = w_ord;    w_b = r_b2[w_ya]; end
            OP_BB:   begin w_a = r_b[w_xa]; w_b = r_b2[w_ya]; end
            OP_BO:   begin w_a = r_b[w_xa]; w_b = w_ord;    end
            default: begin w_a = r_comp ? r_j2[w_xa] : r_j1[w_xa]; w_b = r_x[w_vi]; end
        endcase
    end

    assign w_e_neg = r_log2[8];
    assign w_e_mag = w_e_neg ? 9'(~r_log2 + 9'd1) : r_log2;
    assign w_c_neg = r_count[31];
    assign w_c_mag = w_c_neg ? (~r_count + 32'd1) : r_count;

    assign w_ctl.start = (r_state == S_MMGO);
    assign w_ctl.sel   = r_comp;

    rja_modmac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_acc  ((r_k == 2'd0) ? 32'd0 : r_acc),
        .o_done (w_done),
        .o_res  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ready     <= 1'b0;
            r_log2      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_comp      <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_op        <= OP_AP;
            r_ret       <= S_IDLE;
        end else begin
            if (w_out_acc && r_state != S_RESULT) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                r_ready <= 1'b0;
                unique case (i_cfg_idx)
                    rja_pkg::REG_JUMP_LOG2:  r_log2  <= i_cfg_data[8:0];
                    rja_pkg::REG_JUMP_COUNT: r_count <= i_cfg_data;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_x[0] <= i_in_data.first_word_a;
                        r_x[1] <= i_in_data.first_word_b;
                        r_x[2] <= i_in_data.first_word_c;
                        r_x[3] <= i_in_data.second_word_a;
                        r_x[4] <= i_in_data.second_word_b;
                        r_x[5] <= i_in_data.second_word_c;
                        r_last <= i_in_data.last_stream;
                        r_comp <= 1'b0;
                        r_i <= '0; r_j <= '0; r_k <= '0;
                        if (r_ready) begin
                            r_op    <= OP_AP;
                            r_ret   <= S_RESULT;
                            r_state <= S_MMGO;
                        end else begin
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    for (int q = 0; q < 9; q++) begin
                        r_o[q]  <= (q % 4 == 0) ? 32'd1 : 32'd0;
                        r_b[q]  <= rja_pkg::base_entry(r_comp, w_c_neg, 4'(q));
                        r_b2[q] <= rja_pkg::base_entry(r_comp, w_c_neg, 4'(q));
                    end
                    r_n     <= w_c_mag;
                    r_state <= S_CTEST;
                end
                S_CTEST: begin
                    if (r_n == 32'd0) begin
                        r_state <= S_EINIT;
                    end else if (r_n[0]) begin
                        r_op    <= OP_OB;
                        r_n[0]  <= 1'b0;
                        r_ret   <= S_CTEST;
                        r_state <= S_MMGO;
                    end else begin
                        r_op    <= OP_BB;
                        r_n     <= r_n >> 1;
                        r_ret   <= S_CTEST;
                        r_state <= S_MMGO;
                    end
                end
                S_EINIT: begin
                    if (r_log2 == 9'd0) begin
                        r_state <= S_STORE;
                    end else begin
                        for (int q = 0; q < 9; q++) begin
                            r_b[q]  <= rja_pkg::base_entry(r_comp, w_e_neg, 4'(q));
                            r_b2[q] <= rja_pkg::base_entry(r_comp, w_e_neg, 4'(q));
                        end
                        r_cnt   <= w_e_mag;
                        r_state <= S_ELOOP;
                    end
                end
                S_ELOOP: begin
                    r_ret   <= (r_cnt == 9'd0) ? S_STORE : S_ELOOP;
                    r_op    <= (r_cnt == 9'd0) ? OP_BO : OP_BB;
                    r_state <= S_MMGO;
                    if (r_cnt != 9'd0) r_cnt <= r_cnt - 9'd1;
                end
                S_STORE: begin
                    for (int q = 0; q < 9; q++) begin
                        if (r_comp) r_j2[q] <= r_o[q];
                        else        r_j1[q] <= r_o[q];
                    end
                    if (!r_comp) begin
                        r_comp  <= 1'b1;
                        r_state <= S_INIT;
                    end else begin
                        r_ready <= 1'b1;
                        r_comp  <= 1'b0;
                        r_op    <= OP_AP;
                        r_ret   <= S_RESULT;
                        r_state <= S_MMGO;
                    end
                end
                S_MMGO: begin
                    r_state <= S_MMWT;
                end
                S_MMWT: begin
                    if (w_done) begin
                        r_acc <= w_res;
                        if (r_k != 2'd2) begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_MMGO;
                        end else begin
                            r_k <= '0;
                            if (r_op == OP_AP) begin
                                r_y[w_yi] <= w_res;
                                if (r_i != 2'd2) begin
                                    r_i     <= r_i + 2'd1;
                                    r_state <= S_MMGO;
                                end else if (!r_comp) begin
                                    r_i     <= '0;
                                    r_comp  <= 1'b1;
                                    r_state <= S_MMGO;
                                end else begin
                                    r_i     <= '0;
                                    r_state <= r_ret;
                                end
                            end else begin
                                r_r[4'(r_i) * 4'd3 + 4'(r_j)] <= w_res;
                                if (r_j != 2'd2) begin
                                    r_j     <= r_j + 2'd1;
                                    r_state <= S_MMGO;
                                end else if (r_i != 2'd2) begin
                                    r_j     <= '0;
                                    r_i     <= r_i + 2'd1;
                                    r_state <= S_MMGO;
                                end else begin
                                    r_j     <= '0;
                                    r_i     <= '0;
                                    r_state <= S_MMCP;
                                end
                            end
                        end
                    end
                end
                S_MMCP: begin
                    for (int q = 0; q < 9; q++) begin
                        if (r_op == OP_BB) begin
                            r_b[q]  <= r_r[q];
                            r_b2[q] <= r_r[q];
                        end else begin
                            r_o[q] <= r_r[q];
                        end
                    end
                    r_state <= r_ret;
                end
                S_RESULT: begin
                    if (!r_out_valid || w_out_acc) begin
                        r_out.new_first_a  <= r_y[0];
                        r_out.new_first_b  <= r_y[1];
                        r_out.new_first_c  <= r_y[2];
                        r_out.new_second_a <= r_y[3];
                        r_out.new_second_b <= r_y[4];
                        r_out.new_second_c <= r_y[5];
                        r_out.batch_end    <= r_last;
                        r_out_valid        <= 1'b1;
                        r_comp             <= 1'b0;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ===== design/rja_modmac.sv =====
// Shared modular multiply-accumulate unit: (acc + a*b) mod m.
`timescale 1ns / 1ps
module rja_modmac (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rja_pkg::t_mac_ctl i_ctl,
    input  rja_pkg::t_word   i_a,
    input  rja_pkg::t_word   i_b,
    input  rja_pkg::t_word   i_acc,
    output logic             o_done,
    output rja_pkg::t_word   o_res
);
    logic [63:0]    r_p;
    logic [47:0]    r_t;
    rja_pkg::t_word r_r;
    rja_pkg::t_word r_acc;
    logic           r_sel;
    logic           r_v1, r_v2, r_v3, r_done;

    logic [14:0]    w_d;
    logic [32:0]    w_m;
    logic [47:0]    w_t;
    logic [32:0]    w_u;
    logic [32:0]    w_s;

    assign w_d = r_sel ? rja_pkg::DIFF_TWO : rja_pkg::DIFF_ONE;
    assign w_m = {1'b0, (r_sel ? rja_pkg::MOD_TWO : rja_pkg::MOD_ONE)};
    assign w_t = 48'(r_p[63:32]) * 48'(w_d) + 48'(r_p[31:0]);
    assign w_u = 33'(r_t[47:32]) * 33'(w_d) + 33'(r_t[31:0]);
    assign w_s = 33'(r_acc) + 33'(r_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_ctl.start;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_done <= r_v3;
        end
        if (i_ctl.start) begin
            r_p   <= 64'(i_a) * 64'(i_b);
            r_acc <= i_acc;
            r_sel <= i_ctl.sel;
        end
        r_t <= w_t;
        r_r <= (w_u >= w_m) ? 32'(w_u - w_m) : w_u[31:0];
        o_res <= (w_s >= w_m) ? 32'(w_s - w_m) : w_s[31:0];
    end

    assign o_done = r_done;
endmodule

// ===== verif/rja_checker.sv =====
// Checker for the jump-ahead engine: tracks config, predicts advanced states, compares results.
`timescale 1ns / 1ps
module rja_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  rja_pkg::t_in_req  i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  rja_pkg::t_out_req i_out_data,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_results
);
    typedef rja_pkg::t_word t_mat [9];

    localparam rja_pkg::t_word FWD_ONE  [9] =
        '{0, 1, 0, 0, 0, 1, 32'd4294156359, 32'd1403580, 0};
    localparam rja_pkg::t_word FWD_TWO  [9] =
        '{0, 1, 0, 0, 0, 1, 32'd4293573854, 0, 32'd527612};
    localparam rja_pkg::t_word BACK_ONE [9] =
        '{32'd184888585, 0, 32'd1945170933, 1, 0, 0, 0, 1, 0};
    localparam rja_pkg::t_word BACK_TWO [9] =
        '{0, 32'd360363334, 32'd4225571728, 1, 0, 0, 0, 1, 0};

    logic [8:0]  jump_exp;
    logic [31:0] jump_steps;
    t_mat        jump_one;
    t_mat        jump_two;
    bit          jumps_built;
    rja_pkg::t_out_req advanced_q[$];

    function automatic rja_pkg::t_word mul_acc(input rja_pkg::t_word s,
                                               input rja_pkg::t_word a,
                                               input rja_pkg::t_word b,
                                               input rja_pkg::t_word m);
        logic [63:0] p;
        p = ({32'd0, a} * {32'd0, b}) % {32'd0, m};
        return rja_pkg::t_word'(({32'd0, s} + p) % {32'd0, m});
    endfunction

    function automatic void mat_prod(input t_mat x, input t_mat y, input rja_pkg::t_word m,
                                     output t_mat z);
        rja_pkg::t_word s;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                s = 0;
                for (int k = 0; k < 3; k++) s = mul_acc(s, x[i*3+k], y[k*3+j], m);
                z[i*3+j] = s;
            end
        end
    endfunction

    function automatic void jump_matrix(input t_mat fwd, input t_mat back,
                                        input rja_pkg::t_word m, output t_mat res);
        t_mat b;
        t_mat t;
        bit e_neg;
        bit c_neg;
        logic [9:0]  e_mag;
        logic [31:0] c_mag;
        e_neg = jump_exp[8];
        e_mag = e_neg ? (10'h200 - {1'b0, jump_exp}) : {1'b0, jump_exp};
        c_neg = jump_steps[31];
        c_mag = c_neg ? (32'd0 - jump_steps) : jump_steps;
        b = c_neg ? back : fwd;
        for (int i = 0; i < 9; i++) res[i] = (i % 4 == 0) ? 1 : 0;
        while (c_mag != 0) begin
            if (c_mag[0]) begin
                mat_prod(res, b, m, t);
                res = t;
            end
            mat_prod(b, b, m, t);
            b = t;
            c_mag = c_mag >> 1;
        end
        if (jump_exp != 0) begin
            b = e_neg ? back : fwd;
            for (int i = 0; i < e_mag; i++) begin
                mat_prod(b, b, m, t);
                b = t;
            end
            mat_prod(b, res, m, t);
            res = t;
        end
    endfunction

    function automatic rja_pkg::t_out_req advance_state(input rja_pkg::t_in_req r);
        rja_pkg::t_out_req o;
        rja_pkg::t_word x1 [3];
        rja_pkg::t_word x2 [3];
        rja_pkg::t_word y1 [3];
        rja_pkg::t_word y2 [3];
        x1 = '{r.first_word_a, r.first_word_b, r.first_word_c};
        x2 = '{r.second_word_a, r.second_word_b, r.second_word_c};
        for (int i = 0; i < 3; i++) begin
            y1[i] = 0;
            y2[i] = 0;
            for (int j = 0; j < 3; j++) begin
                y1[i] = mul_acc(y1[i], jump_one[i*3+j], x1[j], rja_pkg::MOD_ONE);
                y2[i] = mul_acc(y2[i], jump_two[i*3+j], x2[j], rja_pkg::MOD_TWO);
            end
        end
        o.new_first_a  = y1[0];
        o.new_first_b  = y1[1];
        o.new_first_c  = y1[2];
        o.new_second_a = y2[0];
        o.new_second_b = y2[1];
        o.new_second_c = y2[2];
        o.batch_end    = r.last_stream;
        return o;
    endfunction

    assign o_pending = advanced_q.size();

    always @(posedge i_clk) begin
        rja_pkg::t_out_req exp_r;
        logic [31:0] got [7];
        logic [31:0] want [7];
        if (!i_rst_n) begin
            jump_exp    = '0;
            jump_steps  = '0;
            jumps_built = 0;
            o_errors    <= 0;
            o_results   <= 0;
            advanced_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == rja_pkg::REG_JUMP_LOG2) jump_exp = i_cfg_data[8:0];
                else jump_steps = i_cfg_data;
                jumps_built = 0;
            end
            if (i_in_valid && !i_in_stall) begin
                if (!jumps_built) begin
                    jump_matrix(FWD_ONE, BACK_ONE, rja_pkg::MOD_ONE, jump_one);
                    jump_matrix(FWD_TWO, BACK_TWO, rja_pkg::MOD_TWO, jump_two);
                    jumps_built = 1;
                end
                advanced_q.push_back(advance_state(i_in_data));
            end
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (advanced_q.size() == 0) begin
                    if (o_errors < 10) $display("ERROR: unexpected result %h", i_out_data);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = advanced_q.pop_front();
                    got  = '{i_out_data.new_first_a, i_out_data.new_first_b,
                             i_out_data.new_first_c, i_out_data.new_second_a,
                             i_out_data.new_second_b, i_out_data.new_second_c,
                             32'(i_out_data.batch_end)};
                    want = '{exp_r.new_first_a, exp_r.new_first_b, exp_r.new_first_c,
                             exp_r.new_second_a, exp_r.new_second_b, exp_r.new_second_c,
                             32'(exp_r.batch_end)};
                    if (got != want) begin
                        for (int f = 0; f < 7; f++) begin
                            if (got[f] != want[f] && o_errors < 10)
                                $display("ERROR: field %0d expected %h got %h",
                                         f, want[f], got[f]);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/tb_rng_jump_ahead_engine_unit.sv =====
// Testbench top for the jump-ahead engine: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_rng_jump_ahead_engine_unit;
    localparam int WATCHDOG_LIMIT = 600000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_stall;
    rja_pkg::t_in_req  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    rja_pkg::t_out_req o_out_data;
    logic     i_cfg_we;
    logic     i_cfg_idx;
    logic [31:0] i_cfg_data;
    int       chk_errors;
    int       chk_pending;
    int       chk_results;
    int       idle_cycles;
    int       sent_reqs;
    int       settings_run;
    bit       quiet;
    bit       hold_req;

    rng_jump_ahead_engine_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    rja_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(chk_errors), .o_pending(chk_pending), .o_results(chk_results)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int n;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_req = 0;
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(3, 0) == 0) begin
                n = $urandom_range(15, 1);
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(20, 1) - 1) @(negedge i_clk);
            end
        end
    end

    function automatic rja_pkg::t_word pick_word(input rja_pkg::t_word m);
        case ($urandom_range(9, 0))
            0: return 32'd0;
            1: return m - 1;
            2: return $urandom;
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(m - 1, 0);
        endcase
    endfunction

    function automatic rja_pkg::t_in_req random_state();
        rja_pkg::t_in_req r;
        r.first_word_a  = pick_word(rja_pkg::MOD_ONE);
        r.first_word_b  = pick_word(rja_pkg::MOD_ONE);
        r.first_word_c  = pick_word(rja_pkg::MOD_ONE);
        r.second_word_a = pick_word(rja_pkg::MOD_TWO);
        r.second_word_b = pick_word(rja_pkg::MOD_TWO);
        r.second_word_c = pick_word(rja_pkg::MOD_TWO);
        r.last_stream   = $urandom_range(1, 0);
        return r;
    endfunction

    task automatic send_state(input rja_pkg::t_in_req r);
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        do @(posedge i_clk); while (o_in_stall);
        sent_reqs++;
        @(negedge i_clk);
        if (!quiet && $urandom_range(3, 0) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic set_jump(input logic [8:0] e, input logic [31:0] c);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rja_pkg::REG_JUMP_LOG2;
        i_cfg_data <= {23'd0, e};
        @(negedge i_clk);
        i_cfg_idx  <= rja_pkg::REG_JUMP_COUNT;
        i_cfg_data <= c;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_run++;
    endtask

    task automatic random_batch(input int n);
        for (int i = 0; i < n; i++) send_state(random_state());
    endtask

    initial begin
        rja_pkg::t_in_req r;
        rja_pkg::t_word edge_words [4];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = rja_pkg::REG_JUMP_LOG2;
        i_cfg_data  = '0;
        quiet       = 0;
        hold_req    = 0;
        sent_reqs   = 0;
        settings_run = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        edge_words = '{32'd0, 32'd1, rja_pkg::MOD_TWO - 1, rja_pkg::MOD_ONE - 1};
        for (int i = 0; i < 4; i++) begin
            r = '{edge_words[i], edge_words[i], edge_words[i],
                  edge_words[i], edge_words[i], edge_words[i], i[0]};
            send_state(r);
        end
        r = '{32'hFFFF_FFFF, rja_pkg::MOD_ONE, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
              rja_pkg::MOD_TWO, rja_pkg::MOD_ONE, 1'b1};
        send_state(r);
        set_jump(9'd1, 32'd1);
        send_state(r);
        random_batch(4);
        set_jump(9'h1FF, 32'hFFFF_FFFF);
        send_state(r);
        random_batch(4);
        set_jump(9'd255, 32'h7FFF_FFFF);
        send_state(r);
        random_batch(100);
        set_jump(9'h100, 32'h8000_0000);
        send_state(r);
        random_batch(100);

        for (int p = 0; p < 8; p++) begin
            if (p % 3 == 0)
                set_jump($urandom, $urandom);
            else
                set_jump(9'($signed($urandom_range(16, 0)) - 8),
                         32'($signed($urandom_range(2000, 0)) - 1000));
            if (p == 7) quiet = 1;
            for (int i = 0; i < 210; i++) begin
                if (p == 2 && i == 50) hold_req = 1;
                send_state(random_state());
            end
        end

        drain();
        $display("Covered %0d stream states over %0d jump settings, %0d results checked",
                 sent_reqs, settings_run, chk_results);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
